### hdl/gamma_curve_evaluator_top_defines.svh
// ----------------------------------------------------------------------------
// gamma curve evaluator assertion macros
// shared property forms for the evaluator's concurrent checks
// ----------------------------------------------------------------------------
`ifndef GAMMA_CURVE_EVALUATOR_TOP_DEFINES_SVH
`define GAMMA_CURVE_EVALUATOR_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define GCE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define GCE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gce_pkg.sv
// ----------------------------------------------------------------------------
// gamma curve evaluator package
// payload types, register codes, gamma limits and elaboration-time math
// ----------------------------------------------------------------------------
package gce_pkg;

    localparam int CODE_W            = 12;
    localparam int GAMMA_W           = 16;
    localparam int FRACTION_BITS     = 16;
    localparam int LOG_FB            = 24;
    localparam int DEF_SHORT_ENTRIES = 1024;
    localparam int DEF_WIDE_ENTRIES  = 4096;

    localparam logic [GAMMA_W-1:0] GAMMA_ONE      = 16'd4096;
    localparam logic [GAMMA_W-1:0] GAMMA_FAIR_MIN = 16'd7373;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX      = 16'd12288;
    localparam logic [GAMMA_W-1:0] GAMMA_FLOOR    = 16'd410;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET    = 16'd9011;
    localparam int                 TEX_TOP        = 255;

    typedef enum logic [1:0] {
        ACT_LIN_TO_SCREEN   = 2'd0,
        ACT_TEX_TO_LIN      = 2'd1,
        ACT_LIN_TO_TEX      = 2'd2,
        ACT_LIN_TO_LIGHTMAP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        OB_ONE     = 2'd0,
        OB_HALF    = 2'd1,
        OB_QUARTER = 2'd2
    } t_overbright;

    typedef enum logic [2:0] {
        REG_SCREEN_GAMMA = 3'd0,
        REG_TEX_GAMMA    = 3'd1,
        REG_OVERBRIGHT   = 3'd2,
        REG_CHEATS       = 3'd3,
        REG_LINEAR_FB    = 3'd4
    } t_reg_idx;

    typedef struct packed {
        t_action             action;
        logic [CODE_W-1:0]   code;
    } t_in;

    typedef struct packed {
        logic [7:0]               byte_value;
        logic [FRACTION_BITS-1:0] fraction_value;
    } t_out;

    // integer square root, one result bit per pass
    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] x;
        r = '0;
        b = 64'h1 << 62;
        x = v;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // 2^(2^-k) in Q1.30, from 2.0 by repeated square roots
    function automatic logic [63:0] exp_root(input int k);
        logic [63:0] root;
        root = 64'h8000_0000;
        for (int i = 1; i <= LOG_FB; i++) begin
            if (i <= k) root = isqrt64(root << 30);
        end
        return root;
    endfunction

    // log2 of a constant in unsigned Q.24, squaring method
    function automatic logic [27:0] log2_q24(input int n);
        int          k;
        logic [63:0] m;
        logic [63:0] f;
        k = 0;
        f = '0;
        for (int b = 1; b <= 20; b++) begin
            if ((n >> b) != 0) k = b;
        end
        m = 64'(n) << (30 - k);
        for (int i = 0; i < LOG_FB; i++) begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'h1 << 31)) begin
                m = m >> 1;
                f = f | 64'h1;
            end
        end
        if (n == 0) return '0;
        return 28'((64'(k) << LOG_FB) | f);
    endfunction

endpackage

### hdl/gamma_curve_evaluator_top.sv
// ----------------------------------------------------------------------------
// gamma curve evaluator
// per-code gamma curve point: log2 by squaring, exponent scale by a
// pipelined divider, exp2 by root products, then byte and fraction packing
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  input     in         i_valid / o_stall     i_data  (action, code)
//  output    out        o_valid / i_stall     o_data  (byte_value, fraction_value)
//  config    in         psel/penable/pwrite   paddr, pwdata, prdata, pready
//
//  one transaction per clock unless o_stall is high; 99 pipeline stages feed
//  the output register, their count set by the 24 log squarings, the 44-step
//  divider and the 24 exp products, one multiplier or subtractor per stage
//  synchronous active-low reset clears valid bits and config registers
//  a skid register behind the output register stalls the pipeline only
//  once a second result is waiting
// ----------------------------------------------------------------------------
module gamma_curve_evaluator_top #(
    parameter int SHORT_ENTRIES = gce_pkg::DEF_SHORT_ENTRIES,
    parameter int WIDE_ENTRIES  = gce_pkg::DEF_WIDE_ENTRIES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  gce_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output gce_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import gce_pkg::*;
    `include "gamma_curve_evaluator_top_defines.svh"

    localparam int LOG_W = 28;
    localparam int DIV_W = LOG_W + GAMMA_W;
    localparam int M_W   = 31;
    localparam int X_W   = 32;
    localparam int Y_W   = 33;

    localparam int ST_NORM  = 1;
    localparam int ST_LOG0  = ST_NORM + 1;
    localparam int ST_DIFF  = ST_LOG0 + LOG_FB;
    localparam int ST_PROD  = ST_DIFF + 1;
    localparam int ST_DIV0  = ST_PROD + 1;
    localparam int ST_ESET  = ST_DIV0 + DIV_W;
    localparam int ST_EXP0  = ST_ESET + 1;
    localparam int ST_Y     = ST_EXP0 + LOG_FB;
    localparam int ST_LAST  = ST_Y + 1;
    localparam int NST      = ST_LAST + 1;

    localparam logic [LOG_W-1:0] LOG_DEN_SHORT = log2_q24(SHORT_ENTRIES - 1);
    localparam logic [LOG_W-1:0] LOG_DEN_TEX   = log2_q24(TEX_TOP);
    localparam logic [LOG_W-1:0] LOG_DEN_WIDE  = log2_q24(WIDE_ENTRIES / 4);

    localparam logic [DIV_W-1:0] E_OVF  = DIV_W'(64'd2 << LOG_FB);
    localparam logic [DIV_W-1:0] E_UNF  = DIV_W'(64'd31 << LOG_FB);
    localparam logic [29:0]      U_BIAS = 30'(64'd32 << LOG_FB);
    localparam logic [X_W-1:0]   MANT_ONE = X_W'(64'h1 << 30);
    localparam logic [Y_W-1:0]   Y_SAT    = Y_W'(64'h1 << 32);
    localparam logic [Y_W-1:0]   FRAC_TOP = Y_W'((64'h1 << FRACTION_BITS) - 1);

    typedef struct packed {
        t_action            action;
        logic               zero;
        logic               neg;
        logic               ovf;
        logic               unf;
        logic [GAMMA_W-1:0] p;
        logic [GAMMA_W-1:0] q;
    } t_side;

    // configuration registers
    logic [GAMMA_W-1:0] r_screen_gamma;
    logic [GAMMA_W-1:0] r_tex_gamma;
    t_overbright        r_ob;
    logic               r_cheats;
    logic               r_lin_fb;

    logic en;
    logic r_vld [NST];
    t_side r_side [ST_LAST];

    logic [CODE_W-1:0] r_code;
    logic [M_W-1:0]    r_lm [LOG_FB+1];
    logic [3:0]        r_lk [LOG_FB+1];
    logic [LOG_FB-1:0] r_lf [LOG_FB+1];
    logic [LOG_W-1:0]  r_mag;
    logic [DIV_W-1:0]  r_dw [DIV_W+1];
    logic [GAMMA_W-1:0] r_dr [DIV_W+1];
    logic [X_W-1:0]    r_xm [LOG_FB+1];
    logic [LOG_FB-1:0] r_xf [LOG_FB+1];
    logic [5:0]        r_xu [LOG_FB+1];
    logic [Y_W-1:0]    r_y;
    t_out              r_pipe;

    t_out r_out;
    logic r_out_valid;
    t_out r_skid;
    logic r_skid_valid;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_gamma <= GAMMA_RESET;
            r_tex_gamma    <= GAMMA_RESET;
            r_ob           <= OB_ONE;
            r_cheats       <= 1'b0;
            r_lin_fb       <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_SCREEN_GAMMA: r_screen_gamma <= pwdata[GAMMA_W-1:0];
                REG_TEX_GAMMA:    r_tex_gamma    <= pwdata[GAMMA_W-1:0];
                REG_OVERBRIGHT:   r_ob           <= t_overbright'(pwdata[1:0]);
                REG_CHEATS:       r_cheats       <= pwdata[0];
                REG_LINEAR_FB:    r_lin_fb       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_SCREEN_GAMMA: prdata = {16'd0, r_screen_gamma};
            REG_TEX_GAMMA:    prdata = {16'd0, r_tex_gamma};
            REG_OVERBRIGHT:   prdata = {30'd0, r_ob};
            REG_CHEATS:       prdata = {31'd0, r_cheats};
            REG_LINEAR_FB:    prdata = {31'd0, r_lin_fb};
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    assign en      = !r_skid_valid;
    assign o_stall = r_skid_valid;

    // stage 0: gamma limits, exponent terms and code saturation
    logic [GAMMA_W-1:0] sg, gs, tg, sgf;
    logic [31:0]        top;
    t_side              n_side0;
    logic [CODE_W-1:0]  n_code;

    always_comb begin
        sg = r_lin_fb ? GAMMA_ONE : r_screen_gamma;
        gs = sg;
        if (!r_cheats && gs < GAMMA_FAIR_MIN) gs = GAMMA_FAIR_MIN;
        if (gs > GAMMA_MAX) gs = GAMMA_MAX;
        if (gs < GAMMA_FLOOR) gs = GAMMA_FLOOR;
        tg  = (r_tex_gamma < GAMMA_FLOOR) ? GAMMA_FLOOR : r_tex_gamma;
        sgf = (sg < GAMMA_FLOOR) ? GAMMA_FLOOR : sg;

        n_side0        = '0;
        n_side0.action = i_data.action;
        n_side0.p      = GAMMA_ONE;
        case (i_data.action)
            ACT_LIN_TO_SCREEN: begin
                top       = 32'(SHORT_ENTRIES - 1);
                n_side0.q = gs;
            end
            ACT_TEX_TO_LIN: begin
                top       = 32'(TEX_TOP);
                n_side0.p = tg;
                n_side0.q = GAMMA_ONE;
            end
            ACT_LIN_TO_TEX: begin
                top       = 32'(SHORT_ENTRIES - 1);
                n_side0.q = tg;
            end
            default: begin
                top       = 32'(WIDE_ENTRIES - 1);
                n_side0.q = sgf;
            end
        endcase
        n_code       = (32'(i_data.code) > top) ? top[CODE_W-1:0] : i_data.code;
        n_side0.zero = (n_code == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= n_side0;
            r_code    <= n_code;
        end
    end

    // valid bits travel down the whole pipeline
    for (genvar s = 1; s < NST; s++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // sign and exp range flags
    logic n_neg;
    logic n_ovf;
    logic n_unf;

    for (genvar s = 1; s < ST_LAST; s++) begin : g_side
        t_side n_side;
        always_comb begin
            n_side = r_side[s-1];
            if (s == ST_DIFF) n_side.neg = n_neg;
            if (s == ST_ESET) begin
                n_side.ovf = n_ovf;
                n_side.unf = n_unf;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_side[s] <= n_side;
            end
        end
    end

    // stage 1: normalize the code to a Q1.30 mantissa
    logic [3:0] n_k;

    always_comb begin
        n_k = '0;
        for (int b = 0; b < CODE_W; b++) begin
            if (r_code[b]) n_k = 4'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lm[0] <= M_W'({r_code, 19'd0} << (4'(CODE_W - 1) - n_k));
            r_lk[0] <= n_k;
            r_lf[0] <= '0;
        end
    end

    // log2 fraction: one squaring per stage
    for (genvar j = 0; j < LOG_FB; j++) begin : g_log
        logic [2*M_W-1:0] w_sq;
        logic [31:0]      w_t;
        assign w_sq = r_lm[j] * r_lm[j];
        assign w_t  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lm[j+1] <= w_t[31] ? w_t[31:1] : w_t[30:0];
                r_lf[j+1] <= {r_lf[j][LOG_FB-2:0], w_t[31]};
                r_lk[j+1] <= r_lk[j];
            end
        end
    end

    // log difference against the curve's denominator
    logic [LOG_W-1:0] log_num;
    logic [LOG_W-1:0] log_den;

    always_comb begin
        log_num = {r_lk[LOG_FB], r_lf[LOG_FB]};
        case (r_side[ST_DIFF-1].action)
            ACT_TEX_TO_LIN:      log_den = LOG_DEN_TEX;
            ACT_LIN_TO_LIGHTMAP: log_den = LOG_DEN_WIDE;
            default:             log_den = LOG_DEN_SHORT;
        endcase
        n_neg = log_num < log_den;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag <= n_neg ? (log_den - log_num) : (log_num - log_den);
        end
    end

    // exponent numerator product
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dw[0] <= DIV_W'(r_mag) * DIV_W'(r_side[ST_PROD-1].p);
            r_dr[0] <= '0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar i = 0; i < DIV_W; i++) begin : g_div
        logic [GAMMA_W:0] w_trial;
        logic [GAMMA_W:0] w_diff;
        logic             w_ge;
        assign w_trial = {r_dr[i], r_dw[i][DIV_W-1]};
        assign w_diff  = w_trial - {1'b0, r_side[ST_DIV0+i-1].q};
        assign w_ge    = w_trial >= {1'b0, r_side[ST_DIV0+i-1].q};
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dr[i+1] <= w_ge ? w_diff[GAMMA_W-1:0] : w_trial[GAMMA_W-1:0];
                r_dw[i+1] <= {r_dw[i][DIV_W-2:0], w_ge};
            end
        end
    end

    // exp setup: range check and biased exponent
    logic [DIV_W-1:0] quo;
    logic             e_neg;
    logic [29:0]      n_u;

    always_comb begin
        quo   = r_dw[DIV_W];
        e_neg = r_side[ST_ESET-1].neg;
        n_ovf = !e_neg && (quo >= E_OVF);
        n_unf = e_neg && (quo > E_UNF);
        n_u   = e_neg ? (U_BIAS - quo[29:0]) : (U_BIAS + quo[29:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_xm[0] <= MANT_ONE;
            r_xf[0] <= n_u[LOG_FB-1:0];
            r_xu[0] <= n_u[29:24];
        end
    end

    // exp2 fraction: one root product per stage
    for (genvar j = 0; j < LOG_FB; j++) begin : g_exp
        localparam logic [63:0] ROOT = exp_root(j + 1);
        logic [X_W+M_W-1:0] w_pr;
        assign w_pr = r_xm[j] * ROOT[M_W-1:0];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_xm[j+1] <= r_xf[j][LOG_FB-1-j] ? w_pr[61:30] : r_xm[j];
                r_xf[j+1] <= r_xf[j];
                r_xu[j+1] <= r_xu[j];
            end
        end
    end

    // integer exponent shift, saturation and overbright
    logic [Y_W-1:0] n_y;
    logic [Y_W-1:0] ym;
    logic [5:0]     ui;

    always_comb begin
        ui = r_xu[LOG_FB];
        ym = {1'b0, r_xm[LOG_FB]};
        if (ui >= 6'd32) n_y = ym << (ui - 6'd32);
        else             n_y = ym >> (6'd32 - ui);
        if (r_side[ST_Y-1].ovf) n_y = Y_SAT;
        if (r_side[ST_Y-1].zero || r_side[ST_Y-1].unf) n_y = '0;
        if (r_side[ST_Y-1].action == ACT_LIN_TO_LIGHTMAP) begin
            case (r_ob)
                OB_HALF:    n_y = n_y >> 1;
                OB_QUARTER: n_y = n_y >> 2;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_y <= n_y;
    end

    // byte and fraction packing
    logic [Y_W+7:0] b_full;
    logic [10:0]    b_int;
    logic [Y_W-1:0] f_full;
    logic [7:0]     n_byte;
    logic [FRACTION_BITS-1:0] n_frac;
    t_out           n_pipe;

    always_comb begin
        b_full = {r_y, 8'd0} - {8'd0, r_y};
        b_int  = b_full[40:30];
        n_byte = (b_int > 11'd255) ? 8'd255 : b_int[7:0];
        f_full = r_y >> (30 - FRACTION_BITS);
        n_frac = (f_full > FRAC_TOP) ? FRAC_TOP[FRACTION_BITS-1:0]
                                     : f_full[FRACTION_BITS-1:0];
        n_pipe = '0;
        case (r_side[ST_LAST-1].action)
            ACT_TEX_TO_LIN:      n_pipe.fraction_value = n_frac;
            ACT_LIN_TO_LIGHTMAP: begin
                n_pipe.byte_value     = n_byte;
                n_pipe.fraction_value = n_frac;
            end
            default:             n_pipe.byte_value = n_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) r_pipe <= n_pipe;
    end

    // ---------------- output register and skid ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            r_out_valid  <= r_skid_valid || r_vld[ST_LAST];
            r_skid_valid <= 1'b0;
        end else if (en && r_vld[ST_LAST]) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : r_pipe;
        end else if (en && r_vld[ST_LAST]) begin
            r_skid <= r_pipe;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // ---------------- assertions ----------------
    `GCE_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid holds a result while the output register is empty")
    `GCE_ASSERT_NXT(a_stall_fills_skid, i_clk, i_rst_n,
        r_out_valid && i_stall && !r_skid_valid && r_vld[ST_LAST], r_skid_valid,
        "stalled pipeline result was not parked in the skid register")
    `GCE_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_vld[ST_ESET-1],
        r_dr[DIV_W] < r_side[ST_ESET-1].q,
        "divider remainder not below divisor")

endmodule
